FILE: src/eti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the eased tween interpolator: widths, codes, state type, ease constants.
// Depends on nothing; used by eased_tween_interpolator_core and its testbench.
package eti_pkg;

   // Fixed-point format: Q16.16 values, Q1.16 progress
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int MODE_W    = 4;
   localparam int PROG_W    = FRAC_BITS + 1;
   localparam int CSR_IDX_W = 3;
   localparam int EASE_W    = 24;

   // Serial multiplier: magnitude widths of the two operands
   localparam int MAG_A_W = 33;
   localparam int MAG_B_W = 23;
   localparam int PROD_W  = MAG_A_W + 1 + MAG_B_W;

   // Serial divider: dividend and divisor widths
   localparam int DVD_W = 48;
   localparam int DVS_W = 33;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd4;

   localparam logic [DATA_W-1:0] DURATION_RESET = 32'd65536;

   // Ease curve codes (13 to 15 fall back to linear)
   typedef enum logic [MODE_W-1:0] {
      EASE_LINEAR    = 4'd0,
      EASE_CUBIC_IN  = 4'd1,
      EASE_CUBIC_OUT = 4'd2,
      EASE_CUBIC_IO  = 4'd3,
      EASE_BACK_IN   = 4'd4,
      EASE_BACK_OUT  = 4'd5,
      EASE_ELASTIC   = 4'd6,
      EASE_BOUNCE    = 4'd7,
      EASE_ACCEL     = 4'd8,
      EASE_DECEL     = 4'd9,
      EASE_ZOOM_IN   = 4'd10,
      EASE_ZOOM_OUT  = 4'd11,
      EASE_REVOLVE   = 4'd12
   } ease_mode_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_M2, ST_M3, ST_IDX, ST_SIN, ST_ELA,
      ST_ZOOM, ST_EASE, ST_POS, ST_INC, ST_OUT
   } eti_state_type;

   // Ease constants in Q16.16
   localparam logic signed [EASE_W-1:0] ONE_E    = 24'sd65536;
   localparam logic signed [EASE_W-1:0] BACK_S   = 24'sd111515;
   localparam logic signed [33:0]       BACK_S1  = 34'sd177051;

   // 2^-y curve coefficients, 24 fraction bits
   localparam longint EXP_B24 = -64'sd11267123;
   localparam longint EXP_C24 = 64'sd2878515;

   // 2^-f for f = k/256, quadratic fit, rounded to 16 fraction bits
   function automatic logic [PROG_W-1:0] exp_entry(input logic [7:0] k);
      longint num;
      longint v;
      num = (64'sd1 <<< 40) + EXP_B24 * longint'(k) * 64'sd256
            + EXP_C24 * longint'(k) * longint'(k);
      v   = num >>> 16;
      v   = (v + 64'sd128) >>> 8;
      return v[PROG_W-1:0];
   endfunction

endpackage

FILE: src/eased_tween_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Eased tween interpolator: sequencer, bit-serial multiplier and divider.
// Depends on eti_pkg.
//
//  channel | ports                              | direction | handshake
//  --------+------------------------------------+-----------+-----------------
//  req     | req_tick_length                    | in        | req_valid/ready
//  rsp     | rsp_position, written, done_res    | out       | rsp_valid/ready
//  csr     | csr_index, csr_wdata               | in        | csr_we, no wait
//
// One word in flight at a time. A delay tick or a finished-tween tick goes straight to the
// output register; other ticks pass through the ease states, using the one-bit shift-add
// multiplier and the restoring divider one at a time.
// A result waits in the output register until rsp_ready; no new word is taken meanwhile.
// Synchronous active-high reset restores the register reset values and clears progress.
module eased_tween_interpolator_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [eti_pkg::DATA_W-1:0]         req_tick_length,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [eti_pkg::DATA_W-1:0]       rsp_position,
   output logic                                    rsp_written,
   output logic                                    rsp_done_res,
   input  wire logic                               csr_we,
   input  wire logic [eti_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [eti_pkg::DATA_W-1:0]         csr_wdata
);
   import eti_pkg::*;

   // Sequencer and configuration
   eti_state_type state_ff, state_in;
   logic go_ff, go_in;
   logic signed [DATA_W-1:0] start_ff, start_in, end_ff, end_in;
   logic [DATA_W-1:0] delay_cfg_ff, delay_cfg_in, duration_ff, duration_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [DATA_W-1:0] rem_delay_ff, rem_delay_in;
   logic [PROG_W-1:0] progress_ff, progress_in;
   logic [DATA_W-1:0] tick_ff, tick_in;
   logic signed [EASE_W-1:0] m1_ff, m1_in, m2_ff, m2_in, e_ff, e_in;
   logic [7:0] idx_ff, idx_in;
   logic signed [DATA_W-1:0] pos_ff, pos_in;
   logic written_ff, written_in, done_ff, done_in;

   // Multiplier
   logic mul_go;
   logic signed [33:0] mul_a;
   logic signed [EASE_W-1:0] mul_b;
   logic [33:0] a_abs;
   logic [EASE_W-1:0] b_abs;
   logic mbusy_ff, mbusy_in, mdone_ff, mdone_in, mneg_ff, mneg_in;
   logic [4:0] mcnt_ff, mcnt_in;
   logic [MAG_A_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] mprod_ff, mprod_in;
   logic [MAG_A_W+1:0] m_sum;
   logic signed [PROD_W-1:0] mprod_s, mq;
   logic signed [EASE_W-1:0] mq24;

   // Divider
   logic div_go;
   logic [DVD_W-1:0] div_dvd;
   logic [DVS_W-1:0] div_dvs;
   logic dbusy_ff, dbusy_in, ddone_ff, ddone_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic [DVD_W-1:0] ddvd_ff, ddvd_in;
   logic [DVS_W-1:0] drem_ff, drem_in, ddvs_ff, ddvs_in;
   logic [DVS_W:0] d_trial, d_diff;
   logic d_fit;

   // Operand helpers
   logic [FRAC_BITS-1:0] t;
   logic signed [EASE_W-1:0] t_s, t2_s, u, wp;
   logic t2_lo;
   logic [EASE_W-1:0] w24;
   logic [1:0] seg;
   logic [19:0] x10;
   logic [PROG_W-1:0] pow;
   logic [17:0] rev_sum;
   logic [7:0] a8;
   logic [16:0] q17;
   logic [21:0] t20, zmag;
   logic z_lt;
   logic [24:0] t400, t420;
   logic [25:0] z11num;
   logic signed [33:0] diff;
   logic signed [EASE_W-1:0] ease_val, sin_val, zoom_val;
   logic signed [PROD_W-1:0] pw;
   logic [DVD_W:0] p_sum;

   // Datapath helpers from progress
   always_comb begin
      t       = progress_ff[FRAC_BITS-1:0];
      t_s     = $signed({8'b0, t});
      t2_s    = $signed({7'b0, t, 1'b0});
      t2_lo   = !t[FRAC_BITS-1];
      w24     = ({8'b0, t} << 3) + ({8'b0, t} << 1) + {8'b0, t};
      if (w24 < 24'd262144)      seg = 2'd0;
      else if (w24 < 24'd524288) seg = 2'd1;
      else if (w24 < 24'd655360) seg = 2'd2;
      else                       seg = 2'd3;
      case (seg)
         2'd0:    wp = $signed(w24);
         2'd1:    wp = $signed(w24) - 24'sd393216;
         2'd2:    wp = $signed(w24) - 24'sd589824;
         default: wp = $signed(w24 << 1) - 24'sd1376256;
      endcase
      x10     = ({4'b0, t} << 3) + ({4'b0, t} << 1);
      pow     = exp_entry(x10[15:8]) >> x10[19:16];
      rev_sum = {2'b0, t} + 18'd98304;
      a8      = {idx_ff[6:0], 1'b0};
      q17     = 17'(a8) * 17'(9'd256 - {1'b0, a8});
      t20     = 22'(t) * 22'd20;
      z_lt    = t20 < 22'd65536;
      zmag    = z_lt ? 22'd65536 - t20 : t20 - 22'd65536;
      t400    = 25'(t) * 25'd400;
      t420    = 25'(t) * 25'd420;
      z11num  = 26'd65536 + 26'(t420);
      diff    = $signed({{2{end_ff[31]}}, end_ff}) - $signed({{2{start_ff[31]}}, start_ff});
      case (mode_ff)
         EASE_CUBIC_OUT, EASE_BACK_OUT: u = t_s - ONE_E;
         EASE_DECEL:                    u = ONE_E - t_s;
         EASE_CUBIC_IO:                 u = t2_lo ? t2_s : t2_s - 24'sd131072;
         EASE_BOUNCE:                   u = wp;
         default:                       u = t_s;
      endcase
   end

   // Unit operands by state
   always_comb begin
      mul_a   = {{10{u[23]}}, u};
      mul_b   = u;
      div_dvd = {tick_ff, 16'b0};
      div_dvs = {1'b0, duration_ff};
      case (state_ff)
         ST_M2: begin
            mul_a = (mode_ff == EASE_BACK_IN || mode_ff == EASE_BACK_OUT)
                    ? BACK_S1 : {{10{m1_ff[23]}}, m1_ff};
         end
         ST_M3: begin
            mul_a = {{10{m1_ff[23]}}, m1_ff};
            mul_b = (mode_ff == EASE_BACK_IN) ? m2_ff - BACK_S : m2_ff + BACK_S;
         end
         ST_ELA: begin
            mul_a = {17'b0, pow};
            mul_b = m2_ff;
         end
         ST_POS: begin
            mul_a = diff;
            mul_b = e_ff;
         end
         ST_IDX: begin
            div_dvd = 48'(x10) + 48'd147456;
            div_dvs = 33'd768;
         end
         ST_SIN: begin
            div_dvd = 48'({q17, 20'b0});
            div_dvs = 33'd327680 - 33'({q17, 2'b0});
         end
         ST_ZOOM: begin
            if (mode_ff == EASE_ZOOM_IN) begin
               div_dvd = 48'({zmag, 16'b0});
               div_dvs = 33'd27525120 - 33'(t400);
            end else begin
               div_dvd = 48'({z11num, 16'b0});
               div_dvs = 33'd1310720 + 33'(t400);
            end
         end
         default: begin
         end
      endcase
   end

   // Shift-add multiplier, one multiplier bit per cycle, sign-magnitude
   always_comb begin
      a_abs    = mul_a[33] ? 34'(-mul_a) : 34'(mul_a);
      b_abs    = mul_b[23] ? 24'(-mul_b) : 24'(mul_b);
      m_sum    = {1'b0, mprod_ff[PROD_W-1:MAG_B_W]}
                 + (mprod_ff[0] ? {2'b0, mcand_ff} : '0);
      mbusy_in = mbusy_ff;
      mdone_in = 1'b0;
      mcnt_in  = mcnt_ff;
      mneg_in  = mneg_ff;
      mcand_in = mcand_ff;
      mprod_in = mprod_ff;
      if (mul_go) begin
         mbusy_in = 1'b1;
         mcnt_in  = 5'(MAG_B_W);
         mneg_in  = mul_a[33] ^ mul_b[23];
         mcand_in = a_abs[MAG_A_W-1:0];
         mprod_in = {{(MAG_A_W+1){1'b0}}, b_abs[MAG_B_W-1:0]};
      end else if (mbusy_ff) begin
         mprod_in = {m_sum, mprod_ff[MAG_B_W-1:1]};
         mcnt_in  = mcnt_ff - 5'd1;
         if (mcnt_ff == 5'd1) begin
            mbusy_in = 1'b0;
            mdone_in = 1'b1;
         end
      end
      mprod_s = mneg_ff ? -$signed({1'b0, mprod_ff[PROD_W-2:0]})
                        : $signed({1'b0, mprod_ff[PROD_W-2:0]});
      mq      = mprod_s >>> FRAC_BITS;
      mq24    = mq[EASE_W-1:0];
   end

   // Restoring divider, one quotient bit per cycle
   always_comb begin
      d_trial  = {drem_ff, ddvd_ff[DVD_W-1]};
      d_diff   = d_trial - {1'b0, ddvs_ff};
      d_fit    = !d_diff[DVS_W];
      dbusy_in = dbusy_ff;
      ddone_in = 1'b0;
      dcnt_in  = dcnt_ff;
      ddvd_in  = ddvd_ff;
      drem_in  = drem_ff;
      ddvs_in  = ddvs_ff;
      if (div_go) begin
         dbusy_in = 1'b1;
         dcnt_in  = 6'(DVD_W);
         ddvd_in  = div_dvd;
         drem_in  = '0;
         ddvs_in  = div_dvs;
      end else if (dbusy_ff) begin
         drem_in = d_fit ? d_diff[DVS_W-1:0] : d_trial[DVS_W-1:0];
         ddvd_in = {ddvd_ff[DVD_W-2:0], d_fit};
         dcnt_in = dcnt_ff - 6'd1;
         if (dcnt_ff == 6'd1) begin
            dbusy_in = 1'b0;
            ddone_in = 1'b1;
         end
      end
   end

   // Ease combine, sine sign and zoom sign
   always_comb begin
      sin_val  = idx_ff[7] ? -$signed(ddvd_ff[EASE_W-1:0]) : $signed(ddvd_ff[EASE_W-1:0]);
      zoom_val = (mode_ff == EASE_ZOOM_IN && z_lt) ? -$signed(ddvd_ff[EASE_W-1:0])
                                                  : $signed(ddvd_ff[EASE_W-1:0]);
      case (mode_ff)
         EASE_CUBIC_IN, EASE_BACK_IN:   ease_val = m2_ff;
         EASE_CUBIC_OUT, EASE_BACK_OUT: ease_val = m2_ff + ONE_E;
         EASE_CUBIC_IO: ease_val = (m2_ff >>> 1) + (t2_lo ? 24'sd0 : ONE_E);
         EASE_ELASTIC:  ease_val = (t == '0) ? 24'sd0 : m1_ff + ONE_E;
         EASE_BOUNCE: begin
            case (seg)
               2'd0:    ease_val = m1_ff >>> 4;
               2'd1:    ease_val = (m1_ff >>> 4) + 24'sd49152;
               2'd2:    ease_val = (m1_ff >>> 4) + 24'sd61440;
               default: ease_val = (m1_ff >>> 6) + 24'sd64512;
            endcase
         end
         EASE_ACCEL:                  ease_val = m1_ff;
         EASE_DECEL:                  ease_val = ONE_E - m1_ff;
         EASE_ZOOM_IN, EASE_ZOOM_OUT: ease_val = m2_ff;
         EASE_REVOLVE:                ease_val = (m2_ff + ONE_E) >>> 1;
         default:                     ease_val = t_s;
      endcase
      pw    = $signed({{(PROD_W-DATA_W){start_ff[31]}}, start_ff}) + mq;
      p_sum = {32'b0, progress_ff} + {1'b0, ddvd_ff};
   end

   // Sequencer: next state, unit launches, captures
   always_comb begin
      state_in     = state_ff;
      go_in        = go_ff;
      mul_go       = 1'b0;
      div_go       = 1'b0;
      start_in     = start_ff;
      end_in       = end_ff;
      delay_cfg_in = delay_cfg_ff;
      duration_in  = duration_ff;
      mode_in      = mode_ff;
      rem_delay_in = rem_delay_ff;
      progress_in  = progress_ff;
      tick_in      = tick_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      e_in         = e_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      written_in   = written_ff;
      done_in      = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tick_in = req_tick_length;
               go_in   = 1'b1;
               if (rem_delay_ff != '0) begin
                  // delay tick: use up delay, no value
                  rem_delay_in = (req_tick_length >= rem_delay_ff)
                                 ? '0 : rem_delay_ff - req_tick_length;
                  pos_in     = '0;
                  written_in = 1'b0;
                  done_in    = 1'b0;
                  state_in   = ST_OUT;
               end else if (progress_ff[FRAC_BITS]) begin
                  // finished: hold the end value
                  pos_in     = end_ff;
                  written_in = 1'b1;
                  done_in    = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  case (mode_ff)
                     EASE_CUBIC_IN, EASE_CUBIC_OUT, EASE_CUBIC_IO, EASE_BACK_IN,
                     EASE_BACK_OUT, EASE_BOUNCE, EASE_ACCEL, EASE_DECEL:
                        state_in = ST_SQ;
                     EASE_ELASTIC: state_in = (t == '0) ? ST_EASE : ST_IDX;
                     EASE_REVOLVE: begin
                        idx_in   = rev_sum[16:9];
                        state_in = ST_SIN;
                     end
                     EASE_ZOOM_IN, EASE_ZOOM_OUT: state_in = ST_ZOOM;
                     default: state_in = ST_EASE;
                  endcase
               end
            end
         end
         ST_SQ: begin
            if (go_ff) begin
               mul_go = 1'b1;
               go_in  = 1'b0;
            end else if (mdone_ff) begin
               m1_in = mq24;
               go_in = 1'b1;
               case (mode_ff)
                  EASE_CUBIC_IN, EASE_CUBIC_OUT, EASE_CUBIC_IO, EASE_BACK_IN,
                  EASE_BACK_OUT: state_in = ST_M2;
                  default:       state_in = ST_EASE;
               endcase
            end
         end
         ST_M2: begin
            if (go_ff) begin
               mul_go = 1'b1;
               go_in  = 1'b0;
            end else if (mdone_ff) begin
               m2_in    = mq24;
               go_in    = 1'b1;
               state_in = (mode_ff == EASE_BACK_IN || mode_ff == EASE_BACK_OUT)
                          ? ST_M3 : ST_EASE;
            end
         end
         ST_M3, ST_ELA: begin
            if (go_ff) begin
               mul_go = 1'b1;
               go_in  = 1'b0;
            end else if (mdone_ff) begin
               if (state_ff == ST_M3) m2_in = mq24;
               else                   m1_in = mq24;
               go_in    = 1'b1;
               state_in = ST_EASE;
            end
         end
         ST_IDX: begin
            if (go_ff) begin
               div_go = 1'b1;
               go_in  = 1'b0;
            end else if (ddone_ff) begin
               idx_in   = ddvd_ff[7:0];
               go_in    = 1'b1;
               state_in = ST_SIN;
            end
         end
         ST_SIN: begin
            if (go_ff) begin
               div_go = 1'b1;
               go_in  = 1'b0;
            end else if (ddone_ff) begin
               m2_in    = sin_val;
               go_in    = 1'b1;
               state_in = (mode_ff == EASE_ELASTIC) ? ST_ELA : ST_EASE;
            end
         end
         ST_ZOOM: begin
            if (go_ff) begin
               div_go = 1'b1;
               go_in  = 1'b0;
            end else if (ddone_ff) begin
               m2_in    = zoom_val;
               go_in    = 1'b1;
               state_in = ST_EASE;
            end
         end
         ST_EASE: begin
            e_in     = ease_val;
            go_in    = 1'b1;
            state_in = ST_POS;
         end
         ST_POS: begin
            if (go_ff) begin
               mul_go = 1'b1;
               go_in  = 1'b0;
            end else if (mdone_ff) begin
               // saturate to the signed 32-bit range
               if (pw > $signed(57'sh7FFFFFFF))       pos_in = 32'sh7FFFFFFF;
               else if (pw < -$signed(57'sh80000000)) pos_in = 32'sh80000000;
               else                                  pos_in = pw[DATA_W-1:0];
               written_in = 1'b1;
               done_in    = 1'b0;
               go_in      = 1'b1;
               state_in   = ST_INC;
            end
         end
         ST_INC: begin
            if (go_ff) begin
               go_in = 1'b0;
               if (duration_ff == '0) begin
                  progress_in = PROG_W'(1 << FRAC_BITS);
                  state_in    = ST_OUT;
               end else begin
                  div_go = 1'b1;
               end
            end else if (ddone_ff) begin
               progress_in = (p_sum > (DVD_W+1)'(1 << FRAC_BITS))
                             ? PROG_W'(1 << FRAC_BITS) : p_sum[PROG_W-1:0];
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            go_in = 1'b0;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // Register writes to indexes up to CSR_MODE restart the tween
      if (csr_we) begin
         case (csr_index)
            CSR_START:    start_in     = $signed(csr_wdata);
            CSR_END:      end_in       = $signed(csr_wdata);
            CSR_DELAY:    delay_cfg_in = csr_wdata;
            CSR_DURATION: duration_in  = csr_wdata;
            CSR_MODE:     mode_in      = csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
         if (csr_index <= CSR_MODE) begin
            rem_delay_in = (csr_index == CSR_DELAY) ? csr_wdata : delay_cfg_ff;
            progress_in  = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         delay_cfg_ff <= '0;
         duration_ff  <= DURATION_RESET;
         mode_ff      <= '0;
         rem_delay_ff <= '0;
         progress_ff  <= '0;
         mbusy_ff     <= 1'b0;
         mdone_ff     <= 1'b0;
         mcnt_ff      <= '0;
         dbusy_ff     <= 1'b0;
         ddone_ff     <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         delay_cfg_ff <= delay_cfg_in;
         duration_ff  <= duration_in;
         mode_ff      <= mode_in;
         rem_delay_ff <= rem_delay_in;
         progress_ff  <= progress_in;
         mbusy_ff     <= mbusy_in;
         mdone_ff     <= mdone_in;
         mcnt_ff      <= mcnt_in;
         dbusy_ff     <= dbusy_in;
         ddone_ff     <= ddone_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tick_ff    <= tick_in;
      m1_ff      <= m1_in;
      m2_ff      <= m2_in;
      e_ff       <= e_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      written_ff <= written_in;
      done_ff    <= done_in;
      mneg_ff    <= mneg_in;
      mcand_ff   <= mcand_in;
      mprod_ff   <= mprod_in;
      ddvd_ff    <= ddvd_in;
      drem_ff    <= drem_in;
      ddvs_ff    <= ddvs_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT);
   assign rsp_position = pos_ff;
   assign rsp_written  = written_ff;
   assign rsp_done_res = done_ff;

   // Checks
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("word accepted while result pending");
   a_prog_sat: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= PROG_W'(1 << FRAC_BITS)) else $error("progress beyond one");
   a_units: assert property (@(posedge clock) disable iff (reset)
      !(mbusy_ff && dbusy_ff)) else $error("multiplier and divider both busy");
   a_done_wr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> rsp_written) else $error("done without value");
   a_delay: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rem_delay_ff != '0 && !csr_we)
      |=> (rsp_valid && !rsp_written)) else $error("delay tick gave a value");

endmodule
`default_nettype wire

FILE: verif/tb_eased_tween_interpolator_core.sv
`timescale 1ns / 1ps
// Testbench for eased_tween_interpolator_core: directed and random ticks against
// a fixed-point tween predictor. Depends on eti_pkg and the core.
module tb_eased_tween_interpolator_core;
   import eti_pkg::*;

   localparam longint ONE        = 64'sd65536;
   localparam int     LIMIT      = 2000000;
   localparam int     RAND_ITEMS = 400;

   typedef struct {
      logic [DATA_W-1:0] position;
      logic              written;
      logic              done_res;
   } tween_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_tick_length = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_position;
   logic              rsp_written;
   logic              rsp_done_res;
   logic              csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   eased_tween_interpolator_core DUT (
      .clock, .reset, .req_valid, .req_ready, .req_tick_length,
      .rsp_valid, .rsp_ready, .rsp_position, .rsp_written, .rsp_done_res,
      .csr_we, .csr_index, .csr_wdata
   );

   always #4 clock = ~clock;

   // Predictor copy of configuration and tween state
   longint tw_start, tw_end, tw_delay, tw_dur, tw_rem, tw_prog;
   logic [MODE_W-1:0] tw_mode;

   tween_word_type pending_q[$];
   int unsigned cycles, n_sent, n_checked, n_errors, burst_left, n_writes;

   function automatic longint round24(longint c);
      return (c + 64'sd128) >>> 8;
   endfunction

   // Bhaskara sine table entry
   function automatic longint sine_at(longint idx);
      longint a, q, v;
      logic   neg;
      a = 2 * (idx % 256);
      neg = (a >= 256);
      if (neg) a = a - 256;
      q = a * (256 - a);
      v = ((16 * q) <<< 16) / (5 * 65536 - 4 * q);
      return neg ? -v : v;
   endfunction

   function automatic longint exp2_neg(longint x);
      longint n, k, num, v;
      n = x >>> 16;
      k = ((x & (ONE - 1)) * 256) >>> 16;
      num = (64'sd1 <<< 24) * 65536 + EXP_B24 * k * 256 + EXP_C24 * k * k;
      v = round24(num / 65536);
      if (n > 62) return 0;
      return v >>> n;
   endfunction

   function automatic longint qm(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint ease_curve(longint t);
      longint u, w, s, s1;
      s  = round24(64'sd28547775);
      s1 = round24(64'sd45324991);
      case (ease_mode_type'(tw_mode))
         EASE_CUBIC_IN:  return qm(qm(t, t), t);
         EASE_CUBIC_OUT: begin
            u = t - ONE;
            return qm(qm(u, u), u) + ONE;
         end
         EASE_CUBIC_IO: begin
            u = 2 * t;
            if (u < ONE) return qm(qm(u, u), u) >>> 1;
            u = u - 2 * ONE;
            return (qm(qm(u, u), u) >>> 1) + ONE;
         end
         EASE_BACK_IN:   return qm(qm(t, t), qm(s1, t) - s);
         EASE_BACK_OUT: begin
            u = t - ONE;
            return qm(qm(u, u), qm(s1, u) + s) + ONE;
         end
         EASE_ELASTIC: begin
            if (t == 0) return 0;
            if (t >= ONE) return ONE;
            u = sine_at(((10 * t + 9 * ONE / 4) * 256) / (3 * ONE));
            return qm(exp2_neg(10 * t), u) + ONE;
         end
         EASE_BOUNCE: begin
            w = 11 * t;
            if (w < 4 * ONE) return (w * w) >>> 20;
            if (w < 8 * ONE) begin
               w = w - 6 * ONE;
               return ((w * w) >>> 20) + 3 * ONE / 4;
            end
            if (w < 10 * ONE) begin
               w = w - 9 * ONE;
               return ((w * w) >>> 20) + 15 * ONE / 16;
            end
            w = 22 * t - 21 * ONE;
            return ((w * w) >>> 22) + 63 * ONE / 64;
         end
         EASE_ACCEL:     return qm(t, t);
         EASE_DECEL: begin
            u = ONE - t;
            return ONE - qm(u, u);
         end
         EASE_ZOOM_IN:   return ((20 * t - ONE) * ONE) / (20 * (21 * ONE - 20 * t));
         EASE_ZOOM_OUT:  return ((ONE + 420 * t) * ONE) / (20 * ONE + 400 * t);
         EASE_REVOLVE: begin
            u = sine_at(((t + 3 * ONE / 2) * 256) / (2 * ONE));
            return (u + ONE) >>> 1;
         end
         default:        return t;
      endcase
   endfunction

   // Advance the tween by one tick and give the word it should produce
   function automatic tween_word_type tween_tick(longint tick);
      tween_word_type r;
      longint pos, inc;
      r = '{position: '0, written: 1'b0, done_res: 1'b0};
      if (tw_rem > 0) begin
         tw_rem = (tick >= tw_rem) ? 0 : tw_rem - tick;
      end else if (tw_prog < ONE) begin
         pos = tw_start + (((tw_end - tw_start) * ease_curve(tw_prog)) >>> 16);
         if (pos > 64'sd2147483647) pos = 64'sd2147483647;
         if (pos < -64'sd2147483648) pos = -64'sd2147483648;
         inc = (tw_dur != 0) ? (tick <<< 16) / tw_dur : ONE;
         tw_prog = tw_prog + inc;
         if (tw_prog > ONE) tw_prog = ONE;
         r.position = pos[DATA_W-1:0];
         r.written = 1'b1;
      end else begin
         r.position = tw_end[DATA_W-1:0];
         r.written = 1'b1;
         r.done_res = 1'b1;
      end
      return r;
   endfunction

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_q.size());
         $display("[eased_tween_interpolator_core] ERROR");
         $finish;
      end
   end

   // Receiver stall pattern: runs of ready or stall of random length
   int unsigned rdy_hold;
   always @(posedge clock) begin
      if (rdy_hold == 0) begin
         rdy_hold <= $urandom_range(1, 24);
         if ($urandom_range(0, 3) == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 2) != 0);
      end else begin
         rdy_hold <= rdy_hold - 1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      tween_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10) $display("unexpected word: pos %h", rsp_position);
         end else begin
            e = pending_q.pop_front();
            n_checked <= n_checked + 1;
            if (rsp_position !== e.position || rsp_written !== e.written
                || rsp_done_res !== e.done_res) begin
               n_errors <= n_errors + 1;
               if (n_errors < 10)
                  $display("mismatch word %0d: exp pos %h wr %b done %b, got pos %h wr %b done %b",
                           n_checked, e.position, e.written, e.done_res,
                           rsp_position, rsp_written, rsp_done_res);
            end
         end
      end
   end

   // Send one tick; the sender runs in bursts with random gaps
   task automatic send_tick(input logic [DATA_W-1:0] tick);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_tick_length <= tick;
      do @(posedge clock); while (!req_ready);
      pending_q.push_back(tween_tick(longint'(tick)));
      n_sent++;
      burst_left--;
   endtask

   // Register write, only once every word has come back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START:    tw_start = longint'(signed'(data));
         CSR_END:      tw_end = longint'(signed'(data));
         CSR_DELAY:    tw_delay = longint'(data);
         CSR_DURATION: tw_dur = longint'(data);
         CSR_MODE:     tw_mode = data[MODE_W-1:0];
         default:      ;
      endcase
      tw_rem = tw_delay;
      tw_prog = 0;
      n_writes++;
   endtask

   task automatic set_tween(input logic [31:0] sv, input logic [31:0] ev, input logic [31:0] dl,
                            input logic [31:0] du, input logic [3:0] md);
      write_reg(CSR_START, sv);
      write_reg(CSR_END, ev);
      write_reg(CSR_DELAY, dl);
      write_reg(CSR_DURATION, du);
      write_reg(CSR_MODE, {28'd0, md});
   endtask

   // Defaults after reset: zero span, linear, duration 1.0
   task automatic test_reset_values();
      send_tick(32'h0000_8000);
      send_tick(32'h0000_8000);
      send_tick(32'h0000_0000);
   endtask

   // Start delay, including a tick that overshoots the remaining delay
   task automatic test_start_delay();
      set_tween(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000, 32'h0002_0000, EASE_LINEAR);
      send_tick(32'h0001_0000);
      send_tick(32'h0000_0000);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'h0000_C000);
   endtask

   // Each ease curve at the start and once mid-way; unused codes only at the start
   task automatic test_every_curve();
      for (int m = 0; m < 16; m++) begin
         set_tween(32'hFF9C_0000, 32'h012C_0000, 32'h0, 32'h0001_0000, m[3:0]);
         send_tick(32'h0000_5000);
         if (m < 13) send_tick(32'h0000_0000);
      end
   endtask

   // Extremes: overflow saturation, tiny and huge durations, done ticks
   task automatic test_extremes();
      set_tween(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, EASE_BACK_OUT);
      send_tick(32'h0000_4000);
      send_tick(32'h0000_4000);
      write_reg(CSR_DURATION, 32'h0000_0001);
      send_tick(32'h0000_0001);
      send_tick(32'hFFFF_FFFF);
      write_reg(CSR_DURATION, 32'hFFFF_FFFF);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'h0000_0000);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom();
         default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      endcase
   endfunction

   // Random tweens: mostly played through to done, some noise ticks
   task automatic test_random_tweens();
      logic [31:0] du, dl, tk;
      int unsigned steps;
      while (n_sent < RAND_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       du = $urandom();
            1:       du = $urandom_range(1, 255);
            default: du = $urandom_range(1, 8) << 16;
         endcase
         dl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3 << 16) : 32'h0;
         if ($urandom_range(0, 15) == 0) dl = $urandom();
         set_tween(rand_value(), rand_value(), dl, du, 4'($urandom_range(0, 15)));
         steps = $urandom_range(6, 16);
         repeat (steps) begin
            case ($urandom_range(0, 7))
               0:       tk = $urandom();
               1:       tk = 32'h0;
               default: tk = du / $urandom_range(2, 8) + $urandom_range(0, 3);
            endcase
            send_tick(tk);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      tw_start = 0; tw_end = 0; tw_delay = 0; tw_dur = 65536; tw_mode = '0;
      tw_rem = 0; tw_prog = 0;
      @(posedge clock);
      test_reset_values();
      test_start_delay();
      test_every_curve();
      test_extremes();
      test_random_tweens();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("ran %0d ticks over %0d register writes, %0d words checked, %0d errors",
               n_sent, n_writes, n_checked, n_errors);
      if (n_errors == 0 && pending_q.size() == 0) begin
         $display("[eased_tween_interpolator_core] OK");
      end else begin
         $display("[eased_tween_interpolator_core] ERROR");
      end
      $finish;
   end

endmodule
